FILE: design/swfc_pkg.sv
// ----------------------------------------------------------------------------
// swfc_pkg
// Shared types and constants for the stream window flow control block.
// ----------------------------------------------------------------------------
package swfc_pkg;

  localparam logic [30:0] MAX31      = 31'h7FFF_FFFF;
  localparam logic [3:0]  FLOW_ERROR = 4'd7;
  localparam int          QUEUE_DEPTH = 2;

  // Event codes on the request channel.
  typedef enum logic [2:0] {
    OP_OPEN     = 3'd0,
    OP_FRAME    = 3'd1,
    OP_CONSUMED = 3'd2,
    OP_DELTA    = 3'd3,
    OP_SEND     = 3'd4,
    OP_SILENT   = 3'd5,
    OP_RESET    = 3'd6,
    OP_UNUSED   = 3'd7
  } op_t;

  // Frame kinds on the result channel.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_RST    = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FLOW_ON   = 3'd0,
    REG_INIT_SEND = 3'd1,
    REG_INIT_RECV = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_STREAM    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [23:0]        byte_count;
    logic signed [31:0] window_delta;
    logic               is_control;
    logic               end_flag;
    logic [3:0]         reset_reason;
  } req_t;

  typedef struct packed {
    logic [1:0]         frame_kind;
    logic [30:0]        frame_stream;
    logic [30:0]        frame_amount;
    logic               frame_fin;
    logic [3:0]         frame_reason;
    logic               frame_accepted;
    logic               request_rejected;
    logic               send_pending;
    logic               stream_aborted;
    logic [30:0]        receive_window_now;
    logic signed [31:0] send_window_now;
  } res_t;

  typedef struct packed {
    logic        flow_control_on;
    logic [30:0] initial_send_window;
    logic [30:0] initial_receive_window;
    logic [30:0] update_threshold;
    logic [30:0] stream_number;
  } cfg_t;

  // One-hot event class produced by the front end.
  typedef struct packed {
    logic open;
    logic frame;
    logic consumed;
    logic delta;
    logic send;
    logic silent;
    logic rst;
  } cls_t;

  // Classified event as it sits in the queue.
  typedef struct packed {
    cls_t               cls;
    logic [23:0]        byte_count;
    logic signed [31:0] window_delta;
    logic               is_control;
    logic               end_flag;
    logic [3:0]         reset_reason;
  } cmd_t;

endpackage

FILE: design/stream_window_flow_control.sv
// ----------------------------------------------------------------------------
// stream_window_flow_control
// Per-stream credit flow control: receive and send windows, window updates,
// chunked sends and stream resets, one event per request.
// ----------------------------------------------------------------------------
// Timing: an accepted request is written into the queue, and the back end
// registers its result once the result register is free or being drained.
// Throughput: one request per cycle while the result side does not stall;
// the two-entry queue absorbs short result stalls.
// Reset: synchronous rst clears the queue and the result valid flag, loads the
// default configuration and returns the stream to its reset windows.
module stream_window_flow_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  swfc_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output swfc_pkg::res_t res_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [30:0]    cfg_data
);

  // Configuration registers. The user is to change them only while the block
  // is idle, which it does not enforce; the back end reads them directly when an event executes.
  swfc_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_control_on        <= 1'b1;
      cfg.initial_send_window    <= 31'd65536;
      cfg.initial_receive_window <= 31'd65536;
      cfg.update_threshold       <= 31'd8192;
      cfg.stream_number          <= 31'd1;
    end else if (cfg_we) begin
      case (swfc_pkg::reg_idx_t'(cfg_index))
        swfc_pkg::REG_FLOW_ON:   cfg.flow_control_on        <= cfg_data[0];
        swfc_pkg::REG_INIT_SEND: cfg.initial_send_window    <= cfg_data;
        swfc_pkg::REG_INIT_RECV: cfg.initial_receive_window <= cfg_data;
        swfc_pkg::REG_THRESHOLD: cfg.update_threshold       <= cfg_data;
        swfc_pkg::REG_STREAM:    cfg.stream_number          <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front end classifies each request and pushes it into the queue; it
  // stalls the request channel only when the queue is full.
  logic           push;
  swfc_pkg::cmd_t push_cmd;
  logic           queue_full;
  logic           queue_nonempty;
  logic           pop;
  swfc_pkg::cmd_t head;

  swfc_front u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  swfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .nonempty (queue_nonempty),
    .pop      (pop),
    .head     (head)
  );

  // The back end executes the queue head whenever the result register is
  // free or being drained in the same cycle.
  swfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .nonempty  (queue_nonempty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

`ifndef SYNTHESIS
  // Aborting always drops the pending send.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.stream_aborted && res_data.send_pending))
    else $error("aborted stream still reports pending bytes");

  // Every reset frame leaves the stream aborted.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.frame_kind == swfc_pkg::KIND_RST))
      |-> res_data.stream_aborted)
    else $error("reset frame without abort");

  // A refused send only happens while bytes are still pending.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.request_rejected) |-> res_data.send_pending)
    else $error("send rejected with nothing pending");

  // The request side stalls only when the queue holds work.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> queue_nonempty)
    else $error("request stalled with an empty queue");
`endif

endmodule

FILE: design/swfc_front.sv
// ----------------------------------------------------------------------------
// swfc_front
// Accepts requests and classifies the event code into a one-hot class.
// ----------------------------------------------------------------------------
module swfc_front (
  input  logic          req_valid,
  output logic          req_stall,
  input  swfc_pkg::req_t req_data,
  output logic          push,
  output swfc_pkg::cmd_t push_cmd,
  input  logic          queue_full
);

  swfc_pkg::cls_t cls;

  always_comb begin
    cls = '0;
    case (swfc_pkg::op_t'(req_data.op))
      swfc_pkg::OP_OPEN:     cls.open     = 1'b1;
      swfc_pkg::OP_FRAME:    cls.frame    = 1'b1;
      swfc_pkg::OP_CONSUMED: cls.consumed = 1'b1;
      swfc_pkg::OP_DELTA:    cls.delta    = 1'b1;
      swfc_pkg::OP_SEND:     cls.send     = 1'b1;
      swfc_pkg::OP_SILENT:   cls.silent   = 1'b1;
      swfc_pkg::OP_RESET:    cls.rst      = 1'b1;
      default:               cls          = '0;
    endcase
  end

  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full;

  always_comb begin
    push_cmd.cls          = cls;
    push_cmd.byte_count   = req_data.byte_count;
    push_cmd.window_delta = req_data.window_delta;
    push_cmd.is_control   = req_data.is_control;
    push_cmd.end_flag     = req_data.end_flag;
    push_cmd.reset_reason = req_data.reset_reason;
  end

endmodule

FILE: design/swfc_queue.sv
// ----------------------------------------------------------------------------
// swfc_queue
// Two-entry queue of classified events between the front and back ends.
// ----------------------------------------------------------------------------
module swfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  swfc_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           nonempty,
  input  logic           pop,
  output swfc_pkg::cmd_t head
);

  localparam int PW = $clog2(swfc_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(swfc_pkg::QUEUE_DEPTH + 1);

  swfc_pkg::cmd_t entries [swfc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(swfc_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(swfc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(swfc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/swfc_back.sv
// ----------------------------------------------------------------------------
// swfc_back
// Holds the stream windows, executes one event per cycle while the result
// side does not stall, and registers the result frame.
// ----------------------------------------------------------------------------
module swfc_back (
  input  logic           clk,
  input  logic           rst,
  input  swfc_pkg::cfg_t cfg,
  input  logic           nonempty,
  input  swfc_pkg::cmd_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output swfc_pkg::res_t res_data
);

  // Stream state.
  logic               aborted_mark;
  logic [30:0]        receive_window;
  logic [30:0]        consumed_total;
  logic signed [31:0] send_window;
  logic [23:0]        pending_bytes;
  logic               pending_fin;

  logic               aborted_mark_next;
  logic [30:0]        receive_window_next;
  logic [30:0]        consumed_total_next;
  logic signed [31:0] send_window_next;
  logic [23:0]        pending_bytes_next;
  logic               pending_fin_next;

  swfc_pkg::res_t     res_next;

  // Shared arithmetic.
  logic                flow;
  logic [31:0]         consumed_sum;
  logic [30:0]         consumed_sat;
  logic [31:0]         recv_sum;
  logic signed [32:0]  delta_sum;
  logic                delta_bad;
  logic signed [31:0]  chunk_window;
  logic [23:0]         chunk_pending;
  logic                chunk_pfin;
  logic                chunk_go;
  logic [23:0]         chunk;
  logic [23:0]         chunk_left;

  assign pop = nonempty && (!res_valid || !res_stall);
  assign flow = cfg.flow_control_on;

  assign consumed_sum = {1'b0, consumed_total} + {8'd0, head.byte_count};
  assign consumed_sat = consumed_sum[31] ? swfc_pkg::MAX31 : consumed_sum[30:0];
  assign recv_sum     = {1'b0, receive_window} + {1'b0, consumed_sat};
  assign delta_sum    = {send_window[31], send_window}
                      + {head.window_delta[31], head.window_delta};
  assign delta_bad    = (delta_sum > $signed({2'b00, swfc_pkg::MAX31}))
                     || (delta_sum < -$signed({2'b00, swfc_pkg::MAX31}));

  // One chunk send serves both a window delta and a new send request.
  always_comb begin
    if (head.cls.delta) begin
      chunk_window  = delta_sum[31:0];
      chunk_pending = pending_bytes;
      chunk_pfin    = pending_fin;
    end else begin
      chunk_window  = send_window;
      chunk_pending = head.byte_count;
      chunk_pfin    = head.end_flag;
    end
    chunk_go = (chunk_pending != '0) && (chunk_window > 32'sd0);
    if ($signed({1'b0, chunk_window}) > $signed({9'd0, chunk_pending})) begin
      chunk = chunk_pending;
    end else begin
      chunk = chunk_window[23:0];
    end
    chunk_left = chunk_pending - chunk;
  end

  always_comb begin
    aborted_mark_next   = aborted_mark;
    receive_window_next = receive_window;
    consumed_total_next = consumed_total;
    send_window_next    = send_window;
    pending_bytes_next  = pending_bytes;
    pending_fin_next    = pending_fin;

    res_next = '0;

    if (head.cls.open) begin
      aborted_mark_next   = 1'b0;
      receive_window_next = cfg.initial_receive_window;
      consumed_total_next = '0;
      send_window_next    = {1'b0, cfg.initial_send_window};
      pending_bytes_next  = '0;
      pending_fin_next    = 1'b0;
    end else if (head.cls.frame) begin
      if (!aborted_mark) begin
        if (!head.is_control && flow
            && ({7'd0, head.byte_count} > receive_window)) begin
          res_next.frame_kind   = swfc_pkg::KIND_RST;
          res_next.frame_reason = swfc_pkg::FLOW_ERROR;
          aborted_mark_next     = 1'b1;
          pending_bytes_next    = '0;
          pending_fin_next      = 1'b0;
        end else begin
          if (!head.is_control && flow) begin
            receive_window_next = receive_window - {7'd0, head.byte_count};
          end
          res_next.frame_accepted = 1'b1;
        end
      end
    end else if (head.cls.consumed) begin
      if (flow && (head.byte_count != '0) && !aborted_mark) begin
        if (consumed_sat >= cfg.update_threshold) begin
          res_next.frame_kind   = swfc_pkg::KIND_UPDATE;
          res_next.frame_amount = consumed_sat;
          receive_window_next   = recv_sum[31] ? swfc_pkg::MAX31 : recv_sum[30:0];
          consumed_total_next   = '0;
        end else begin
          consumed_total_next = consumed_sat;
        end
      end
    end else if (head.cls.delta) begin
      if (flow && !aborted_mark) begin
        if (delta_bad) begin
          res_next.frame_kind   = swfc_pkg::KIND_RST;
          res_next.frame_reason = swfc_pkg::FLOW_ERROR;
          aborted_mark_next     = 1'b1;
          pending_bytes_next    = '0;
          pending_fin_next      = 1'b0;
        end else begin
          send_window_next = delta_sum[31:0];
          if (chunk_go) begin
            res_next.frame_kind   = swfc_pkg::KIND_DATA;
            res_next.frame_amount = {7'd0, chunk};
            res_next.frame_fin    = (chunk_left == '0) && chunk_pfin;
            send_window_next      = delta_sum[31:0] - {8'd0, chunk};
            pending_bytes_next    = chunk_left;
            if (chunk_left == '0) begin
              pending_fin_next = 1'b0;
            end
          end
        end
      end
    end else if (head.cls.send) begin
      if (!aborted_mark) begin
        if (pending_bytes != '0) begin
          res_next.request_rejected = 1'b1;
        end else if (!flow || (head.byte_count == '0)) begin
          if ((head.byte_count != '0) || head.end_flag) begin
            res_next.frame_kind   = swfc_pkg::KIND_DATA;
            res_next.frame_amount = {7'd0, head.byte_count};
            res_next.frame_fin    = head.end_flag;
          end
        end else begin
          pending_bytes_next = head.byte_count;
          pending_fin_next   = head.end_flag;
          if (chunk_go) begin
            res_next.frame_kind   = swfc_pkg::KIND_DATA;
            res_next.frame_amount = {7'd0, chunk};
            res_next.frame_fin    = (chunk_left == '0) && chunk_pfin;
            send_window_next      = send_window - {8'd0, chunk};
            pending_bytes_next    = chunk_left;
            if (chunk_left == '0) begin
              pending_fin_next = 1'b0;
            end
          end
        end
      end
    end else if (head.cls.silent) begin
      aborted_mark_next  = 1'b1;
      pending_bytes_next = '0;
      pending_fin_next   = 1'b0;
    end else if (head.cls.rst) begin
      res_next.frame_kind   = swfc_pkg::KIND_RST;
      res_next.frame_reason = head.reset_reason;
      aborted_mark_next     = 1'b1;
      pending_bytes_next    = '0;
      pending_fin_next      = 1'b0;
    end

    res_next.frame_stream       = cfg.stream_number;
    res_next.send_pending       = (pending_bytes_next != '0);
    res_next.stream_aborted     = aborted_mark_next;
    res_next.receive_window_now = receive_window_next;
    res_next.send_window_now    = send_window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aborted_mark   <= 1'b0;
      receive_window <= 31'd65536;
      consumed_total <= '0;
      send_window    <= 32'sd65536;
      pending_bytes  <= '0;
      pending_fin    <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (pop) begin
        aborted_mark   <= aborted_mark_next;
        receive_window <= receive_window_next;
        consumed_total <= consumed_total_next;
        send_window    <= send_window_next;
        pending_bytes  <= pending_bytes_next;
        pending_fin    <= pending_fin_next;
        res_valid      <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= res_next;
    end
  end

endmodule

FILE: dv/window_check_pkg.sv
// ----------------------------------------------------------------------------
// window_check_pkg
// Scoreboard for the stream window flow control block: tracks the stream's
// windows and pending send, and checks every frame the block returns.
// ----------------------------------------------------------------------------
package window_check_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import swfc_pkg::*;

  class window_scoreboard;

    // Copy of the configuration registers.
    logic        flow_on;
    logic [30:0] init_send;
    logic [30:0] init_recv;
    logic [30:0] threshold;
    logic [30:0] stream_num;

    // Copy of the stream state.
    logic        aborted;
    logic [30:0] recv_win;
    logic [30:0] consumed;
    longint      send_win;
    logic [23:0] pend_bytes;
    logic        pend_fin;

    res_t expected_frames[$];
    int   errors;
    int   checked;
    int   kind_seen[4];
    int   refused_sends;

    function new();
      flow_on    = 1'b1;
      init_send  = 31'd65536;
      init_recv  = 31'd65536;
      threshold  = 31'd8192;
      stream_num = 31'd1;
      aborted    = 1'b0;
      recv_win   = 31'd65536;
      consumed   = '0;
      send_win   = 65536;
      pend_bytes = '0;
      pend_fin   = 1'b0;
      errors     = 0;
      checked    = 0;
      refused_sends = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [30:0] value);
      case (idx)
        REG_FLOW_ON:   flow_on    = value[0];
        REG_INIT_SEND: init_send  = value;
        REG_INIT_RECV: init_recv  = value;
        REG_THRESHOLD: threshold  = value;
        REG_STREAM:    stream_num = value;
        default: ;
      endcase
    endfunction

    function void open_stream();
      aborted    = 1'b0;
      recv_win   = init_recv;
      consumed   = '0;
      send_win   = longint'(init_send);
      pend_bytes = '0;
      pend_fin   = 1'b0;
    endfunction

    function void abort_stream();
      aborted    = 1'b1;
      pend_bytes = '0;
      pend_fin   = 1'b0;
    endfunction

    // Moves as much of the pending send as the window allows into one chunk.
    function bit take_chunk(output logic [30:0] amt, output logic fin);
      longint chunk;
      amt = '0;
      fin = 1'b0;
      if (pend_bytes == 0 || send_win <= 0) return 1'b0;
      chunk = longint'(pend_bytes);
      if (chunk > send_win) chunk = send_win;
      amt = 31'(chunk);
      fin = (chunk == longint'(pend_bytes)) && pend_fin;
      send_win   = send_win - chunk;
      pend_bytes = pend_bytes - 24'(chunk);
      if (pend_bytes == 0) pend_fin = 1'b0;
      return 1'b1;
    endfunction

    function res_t predict_frame(req_t r);
      res_t        f;
      longint      sum;
      logic [30:0] amt;
      logic        fin;
      f = '0;
      case (op_t'(r.op))
        OP_OPEN: open_stream();
        OP_FRAME: begin
          if (!aborted) begin
            if (!r.is_control && flow_on && r.byte_count > recv_win) begin
              f.frame_kind   = KIND_RST;
              f.frame_reason = FLOW_ERROR;
              abort_stream();
            end else begin
              if (!r.is_control && flow_on) recv_win = recv_win - 31'(r.byte_count);
              f.frame_accepted = 1'b1;
            end
          end
        end
        OP_CONSUMED: begin
          if (flow_on && r.byte_count != 0 && !aborted) begin
            sum = longint'(consumed) + longint'(r.byte_count);
            consumed = (sum > longint'(MAX31)) ? MAX31 : 31'(sum);
            if (consumed >= threshold) begin
              f.frame_kind   = KIND_UPDATE;
              f.frame_amount = consumed;
              sum = longint'(recv_win) + longint'(consumed);
              recv_win = (sum > longint'(MAX31)) ? MAX31 : 31'(sum);
              consumed = '0;
            end
          end
        end
        OP_DELTA: begin
          if (flow_on && !aborted) begin
            sum = send_win + longint'($signed(r.window_delta));
            if (sum > longint'(MAX31) || sum < -longint'(MAX31)) begin
              f.frame_kind   = KIND_RST;
              f.frame_reason = FLOW_ERROR;
              abort_stream();
            end else begin
              send_win = sum;
              if (take_chunk(amt, fin)) begin
                f.frame_kind   = KIND_DATA;
                f.frame_amount = amt;
                f.frame_fin    = fin;
              end
            end
          end
        end
        OP_SEND: begin
          if (!aborted) begin
            if (pend_bytes != 0) begin
              f.request_rejected = 1'b1;
            end else if (!flow_on || r.byte_count == 0) begin
              if (r.byte_count != 0 || r.end_flag) begin
                f.frame_kind   = KIND_DATA;
                f.frame_amount = 31'(r.byte_count);
                f.frame_fin    = r.end_flag;
              end
            end else begin
              pend_bytes = r.byte_count;
              pend_fin   = r.end_flag;
              if (take_chunk(amt, fin)) begin
                f.frame_kind   = KIND_DATA;
                f.frame_amount = amt;
                f.frame_fin    = fin;
              end
            end
          end
        end
        OP_SILENT: abort_stream();
        OP_RESET: begin
          f.frame_kind   = KIND_RST;
          f.frame_reason = r.reset_reason;
          abort_stream();
        end
        default: ;
      endcase
      f.frame_stream       = stream_num;
      f.send_pending       = (pend_bytes != 0);
      f.stream_aborted     = aborted;
      f.receive_window_now = recv_win;
      f.send_window_now    = 32'(send_win);
      return f;
    endfunction

    function void note_request(req_t r);
      expected_frames.push_back(predict_frame(r));
    endfunction

    function int outstanding();
      return expected_frames.size();
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      checked++;
      kind_seen[got.frame_kind]++;
      if (got.request_rejected) refused_sends++;
      compare_field("frame_kind", want.frame_kind, got.frame_kind);
      compare_field("frame_stream", want.frame_stream, got.frame_stream);
      compare_field("frame_amount", want.frame_amount, got.frame_amount);
      compare_field("frame_fin", want.frame_fin, got.frame_fin);
      compare_field("frame_reason", want.frame_reason, got.frame_reason);
      compare_field("frame_accepted", want.frame_accepted, got.frame_accepted);
      compare_field("request_rejected", want.request_rejected, got.request_rejected);
      compare_field("send_pending", want.send_pending, got.send_pending);
      compare_field("stream_aborted", want.stream_aborted, got.stream_aborted);
      compare_field("receive_window_now", want.receive_window_now,
                    got.receive_window_now);
      compare_field("send_window_now", $signed(want.send_window_now),
                    $signed(got.send_window_now));
    endfunction

  endclass

endpackage

FILE: dv/tb_stream_window_flow_control.sv
// ----------------------------------------------------------------------------
// tb_stream_window_flow_control
// Self-checking bench for the stream window flow control block. A directed
// opening walks the special cases of the stream; then random requests run
// under several register settings while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stream_window_flow_control;

  timeunit 1ns;
  timeprecision 1ps;

  import swfc_pkg::*;
  import window_check_pkg::*;

  // Mixes of random requests: a general one, and one that piles up consumed
  // bytes so that the consumed total and the receive window saturate.
  typedef enum {MIX_GENERAL, MIX_SATURATE} mix_t;

  localparam int HOLD_OFF_CYCLES = 64;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_data  = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data  = '0;

  window_scoreboard tracker;

  int burst_left       = 0;
  int settings_applied = 0;
  int holdoffs_asked   = 0;
  int holdoffs_done    = 0;

  stream_window_flow_control DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Every result taken at an edge is checked against the oldest prediction.
  // Signals are read right after the edge, so they hold the values that the
  // block itself saw at that edge.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_result(res_data);
  end

  // The receiver runs its own stall pattern in segments: never stalling,
  // stalling now and then, stalling mostly, or toggling every cycle. When
  // the stimulus asks for it, it holds off for a long stretch so that the
  // block's queue fills up and it has to stall the request side.
  initial begin : receiver
    int span;
    int mode;
    forever begin
      if (holdoffs_asked > holdoffs_done) begin
        repeat (HOLD_OFF_CYCLES) begin
          @(posedge clk);
          res_stall <= 1'b1;
        end
        holdoffs_done++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        repeat (span) begin
          @(posedge clk);
          case (mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            2: res_stall <= ($urandom_range(0, 3) != 0);
            default: res_stall <= ~res_stall;
          endcase
        end
      end
    end
  end

  function automatic req_t make_request(op_t op, logic [23:0] count,
                                        logic signed [31:0] delta, logic ctrl,
                                        logic fin, logic [3:0] reason);
    req_t r;
    r.op           = op;
    r.byte_count   = count;
    r.window_delta = delta;
    r.is_control   = ctrl;
    r.end_flag     = fin;
    r.reset_reason = reason;
    return r;
  endfunction

  // Random request. All fields are random whatever the operation, so every
  // bit moves; the operation and the sizes are weighted so that windows
  // actually drain, reopen and overflow.
  function automatic req_t random_request(mix_t mix);
    req_t r;
    int   pick;
    int   mag;
    pick = $urandom_range(0, 99);
    if (mix == MIX_SATURATE) begin
      if (pick < 92)      r.op = OP_CONSUMED;
      else if (pick < 97) r.op = OP_FRAME;
      else                r.op = OP_SEND;
    end else begin
      if (pick < 6)       r.op = OP_OPEN;
      else if (pick < 28) r.op = OP_FRAME;
      else if (pick < 46) r.op = OP_CONSUMED;
      else if (pick < 66) r.op = OP_DELTA;
      else if (pick < 88) r.op = OP_SEND;
      else if (pick < 92) r.op = OP_SILENT;
      else if (pick < 97) r.op = OP_RESET;
      else                r.op = OP_UNUSED;
    end

    pick = $urandom_range(0, 99);
    if (mix == MIX_SATURATE && r.op == OP_CONSUMED && pick < 95)
      r.byte_count = 24'hFF_FFFF;
    else if (pick < 55) r.byte_count = 24'($urandom_range(0, 3000));
    else if (pick < 75) r.byte_count = 24'($urandom_range(0, 100000));
    else if (pick < 92) r.byte_count = 24'($urandom);
    else if (pick < 96) r.byte_count = '0;
    else                r.byte_count = 24'hFF_FFFF;

    // Window deltas: mostly modest, some large, some right at the edge of
    // the legal range so that the send window overflows both ways.
    pick = $urandom_range(0, 99);
    if (pick < 55)      mag = $urandom_range(0, 5000);
    else if (pick < 75) mag = $urandom_range(0, 2000000);
    else if (pick < 90) mag = $urandom_range(0, 32'h7FFF_FFFF);
    else                mag = 32'h7FFF_FFFF - $urandom_range(0, 100000);
    r.window_delta = ($urandom_range(0, 1) != 0) ? -mag : mag;

    r.is_control   = ($urandom_range(0, 4) == 0);
    r.end_flag     = ($urandom_range(0, 19) < 7);
    r.reset_reason = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 11));
    return r;
  endfunction

  // Offers one request and holds it until the block takes it. Between
  // bursts of requests the sender drops valid for a random gap.
  task automatic offer(req_t r);
    int gap;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
    tracker.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  // Each request yields exactly one result, so the block is idle then.
  task automatic drain();
    req_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [30:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.set_register(idx, value);
  endtask

  task automatic apply_settings(logic flow, logic [30:0] send_init,
                                logic [30:0] recv_init, logic [30:0] thr,
                                logic [30:0] stream);
    write_register(REG_FLOW_ON, {30'd0, flow});
    write_register(REG_INIT_SEND, send_init);
    write_register(REG_INIT_RECV, recv_init);
    write_register(REG_THRESHOLD, thr);
    write_register(REG_STREAM, stream);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // One phase: new settings on an idle block, a long hold-off on the
  // result side early on, then a run of random requests.
  task automatic run_phase(logic flow, logic [30:0] send_init,
                           logic [30:0] recv_init, logic [30:0] thr,
                           logic [30:0] stream, int items, mix_t mix);
    drain();
    apply_settings(flow, send_init, recv_init, thr, stream);
    holdoffs_asked++;
    // The saturating mix has no open of its own, so start from a fresh stream.
    if (mix == MIX_SATURATE) offer(make_request(OP_OPEN, '0, '0, 1'b0, 1'b0, 4'd0));
    repeat (items) offer(random_request(mix));
  endtask

  // Directed opening under the reset settings: windows of 65536 and an
  // update threshold of 8192.
  task automatic run_directed();
    offer(make_request(OP_OPEN, '0, '0, 1'b0, 1'b0, 4'd1));
    // A control frame is exempt from the receive window, however large.
    offer(make_request(OP_FRAME, 24'hFF_FFFF, '0, 1'b1, 1'b0, 4'd1));
    // A data frame that exactly fills the receive window is still admitted.
    offer(make_request(OP_FRAME, 24'd65536, '0, 1'b0, 1'b0, 4'd1));
    // Just below the threshold, then reaching it, then a huge amount.
    offer(make_request(OP_CONSUMED, 24'd8191, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_CONSUMED, 24'd1, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_CONSUMED, 24'hFF_FFFF, '0, 1'b0, 1'b0, 4'd1));
    // Empty sends: nothing without the end flag, a zero-length frame with it.
    offer(make_request(OP_SEND, '0, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_SEND, '0, '0, 1'b0, 1'b1, 4'd1));
    // A send larger than the window leaves a remainder pending, and a second
    // send while that remainder waits is refused.
    offer(make_request(OP_SEND, 24'hFF_FFFF, '0, 1'b0, 1'b1, 4'd1));
    offer(make_request(OP_SEND, 24'd5, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_DELTA, '0, 32'sd100, 1'b0, 1'b0, 4'd1));
    // Drive the send window to the negative limit, back to zero (still
    // closed), then fully open so the rest goes out with the end flag.
    offer(make_request(OP_DELTA, '0, -32'sd2147483647, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_DELTA, '0, 32'sd2147483647, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_DELTA, '0, 32'sd2147483647, 1'b0, 1'b0, 4'd1));
    // Positive overflow of the send window resets the stream.
    offer(make_request(OP_DELTA, '0, 32'sd2147483647, 1'b0, 1'b0, 4'd1));
    // On an aborted stream these do nothing.
    offer(make_request(OP_FRAME, 24'd10, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_CONSUMED, 24'd100, '0, 1'b0, 1'b0, 4'd1));
    // A reset abort is emitted again even when already aborted; reasons
    // outside the defined codes pass through.
    offer(make_request(OP_RESET, '0, '0, 1'b0, 1'b0, 4'd0));
    offer(make_request(OP_RESET, '0, '0, 1'b0, 1'b0, 4'd15));
    offer(make_request(OP_UNUSED, 24'd7, 32'sd7, 1'b1, 1'b1, 4'd7));
    // A silent abort drops a pending send.
    offer(make_request(OP_OPEN, '0, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_SEND, 24'hFF_FFFF, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_SILENT, '0, '0, 1'b0, 1'b0, 4'd1));
    // A data frame one byte over the receive window is a flow control error.
    offer(make_request(OP_OPEN, '0, '0, 1'b0, 1'b0, 4'd1));
    offer(make_request(OP_FRAME, 24'd65537, '0, 1'b0, 1'b0, 4'd1));
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Smallest windows and threshold, largest stream number.
    run_phase(1'b1, 31'd1, 31'd1, 31'd1, MAX31, 80, MIX_GENERAL);
    // Flow control off: whole sends, everything admitted; any remainder
    // pending from before stays put.
    run_phase(1'b0, 31'd1000, 31'd1000, MAX31, 31'd1, 70, MIX_GENERAL);
    // Largest windows.
    run_phase(1'b1, MAX31, MAX31, 31'd4096,
              31'($urandom_range(32'h7FFF_FFFF, 1)), 80, MIX_GENERAL);
    // Largest threshold: only a saturated consumed total returns credit.
    run_phase(1'b1, MAX31, MAX31, MAX31, 31'd12345, 200, MIX_SATURATE);
    // Moderate random settings.
    run_phase(1'b1, 31'($urandom_range(70000, 1)), 31'($urandom_range(70000, 1)),
              31'($urandom_range(20000, 1)), 31'($urandom_range(32'h7FFF_FFFF, 1)),
              100, MIX_GENERAL);
    // Back to the reset values.
    run_phase(1'b1, 31'd65536, 31'd65536, 31'd8192, 31'd1, 100, MIX_GENERAL);

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d results across %0d register settings with %0d long hold-offs.",
             tracker.checked, settings_applied + 1, holdoffs_done);
    $display("Frames seen: %0d window updates, %0d data, %0d stream resets, %0d refused sends.",
             tracker.kind_seen[KIND_UPDATE], tracker.kind_seen[KIND_DATA],
             tracker.kind_seen[KIND_RST], tracker.refused_sends);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", tracker.errors,
               tracker.outstanding());
      $display("Regression FAIL");
    end
    $finish;
  end

  // A hang anywhere ends the run well after the slowest legal run would.
  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d results still expected.", tracker.outstanding());
    $display("Regression FAIL");
    $finish;
  end

endmodule
